>>> rtl/core/sorted_threshold_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Sorted threshold table assertion macros
// Shared concurrent assertion forms for the sorted threshold table.
// ----------------------------------------------------------------------------
`ifndef SORTED_THRESHOLD_TABLE_UNIT_MACROS_SVH
`define SORTED_THRESHOLD_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted threshold table package
// Sizes, transaction payload types, operation and status codes and sequencer states.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_LEVEL  = 3'd3,
        OP_EXISTS = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SHUP,
        S_SHDN,
        S_WRNEW,
        S_LEVEL,
        S_RESP
    } fsm_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] key;
        logic [15:0] value;
        logic        use_all_in;
        logic [4:0]  level;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] frames;
        logic        use_all;
        logic [4:0]  level_out;
        logic [15:0] entry_key;
        logic        found;
        logic [4:0]  count;
    } rsp_t;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] frames;
        logic        use_all;
    } entry_t;

endpackage

>>> rtl/core/sorted_threshold_table_unit.sv
// ----------------------------------------------------------------------------
// Sorted threshold table unit
// Holds up to 16 threshold entries sorted ascending in one synchronous RAM.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. The table sits in a single RAM with
// one write and one registered read port, walked one entry per cycle from the
// lowest threshold. A lookup, exists or rejected add walks the entries below
// the stopping point, at most all 16. A successful add or remove also moves
// every entry above the insert or delete point by one slot, one entry per
// cycle. A by-level query reads the selected entry directly, and answers
// without a read when the level is 0 or the table is empty. A finished
// response waits in an output register, so a new request is taken as soon
// as the sequencer is back in idle even while the response is stalled.
// ----------------------------------------------------------------------------
`include "sorted_threshold_table_unit_macros.svh"

module sorted_threshold_table_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  stt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output stt_pkg::rsp_t rsp
);
    import stt_pkg::*;

    // table RAM
    entry_t             mem [DEPTH];
    entry_t             rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic               mem_we;

    fsm_t               state_reg, state_next;
    req_t               item_reg, item_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   src_reg, src_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    entry_t             prev_reg, prev_next;
    rsp_t               res_reg, res_next;
    rsp_t               rsp_reg, rsp_next;
    logic               rsp_valid_reg;
    logic               rsp_load;

    logic [CNT_W-1:0]   idx_plus;
    logic [CNT_W-1:0]   count_m1;
    logic [4:0]         lvl_sel;
    logic               end_scan;
    logic               key_gt;
    logic               key_ge;
    logic               hit;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign idx_plus = idx_reg + 1'b1;
    assign count_m1 = count_reg - 1'b1;
    assign lvl_sel  = (item_reg.level > count_reg) ? count_m1 : (item_reg.level - 1'b1);
    assign end_scan = (idx_reg >= count_reg);
    assign key_gt   = (rd_data_reg.key > item_reg.key);
    assign key_ge   = (rd_data_reg.key >= item_reg.key);
    assign hit      = !end_scan && (rd_data_reg.key == item_reg.key);

    always_comb
    begin
        state_next = state_reg;
        item_next  = item_reg;
        idx_next   = idx_reg;
        src_next   = src_reg;
        count_next = count_reg;
        prev_next  = prev_reg;
        res_next   = res_reg;
        rd_addr    = '0;
        mem_we     = 1'b0;
        wr_addr    = '0;
        wr_data    = rd_data_reg;
        req_stall  = 1'b1;
        rsp_load   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    item_next  = req;
                    idx_next   = '0;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                res_next = '0;
                case (item_reg.op)
                    OP_LEVEL:
                    begin
                        if ((count_reg == '0) || (item_reg.level == '0))
                        begin
                            res_next.use_all = 1'b1;
                            state_next       = S_RESP;
                        end
                        else
                        begin
                            rd_addr    = lvl_sel[IDX_W-1:0];
                            state_next = S_LEVEL;
                        end
                    end
                    OP_ADD, OP_REMOVE, OP_LOOKUP, OP_EXISTS:
                    begin
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_LEVEL:
            begin
                res_next           = '0;
                res_next.entry_key = rd_data_reg.key;
                res_next.use_all   = rd_data_reg.use_all;
                res_next.frames    = rd_data_reg.use_all ? '0 : rd_data_reg.frames;
                state_next         = S_RESP;
            end

            S_SCAN:
            begin
                // read of entry idx+1 is in flight while entry idx is compared
                rd_addr   = idx_plus[IDX_W-1:0];
                idx_next  = idx_plus;
                prev_next = rd_data_reg;
                if (item_reg.op == OP_LOOKUP)
                begin
                    if (end_scan || key_gt)
                    begin
                        res_next           = '0;
                        res_next.level_out = idx_reg;
                        if (idx_reg == '0)
                        begin
                            res_next.use_all = 1'b1;
                        end
                        else
                        begin
                            res_next.use_all = prev_reg.use_all;
                            res_next.frames  = prev_reg.use_all ? '0 : prev_reg.frames;
                        end
                        state_next = S_RESP;
                    end
                end
                else if (end_scan || key_ge)
                begin
                    // idx_reg holds the insert / match position from here on
                    idx_next = idx_reg;
                    res_next = '0;
                    case (item_reg.op)
                        OP_EXISTS:
                        begin
                            res_next.found = hit;
                            state_next     = S_RESP;
                        end
                        OP_ADD:
                        begin
                            if (hit)
                            begin
                                res_next.status = ST_DUP;
                                state_next      = S_RESP;
                            end
                            else if (count_reg == CNT_W'(DEPTH))
                            begin
                                res_next.status = ST_FULL;
                                state_next      = S_RESP;
                            end
                            else if (count_reg > idx_reg)
                            begin
                                rd_addr    = count_m1[IDX_W-1:0];
                                src_next   = count_m1[IDX_W-1:0];
                                state_next = S_SHUP;
                            end
                            else
                            begin
                                state_next = S_WRNEW;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!hit)
                            begin
                                state_next = S_RESP;
                            end
                            else if (idx_plus < count_reg)
                            begin
                                rd_addr    = idx_plus[IDX_W-1:0];
                                src_next   = idx_plus[IDX_W-1:0];
                                state_next = S_SHDN;
                            end
                            else
                            begin
                                count_next = count_m1;
                                state_next = S_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_SHUP:
            begin
                // move entry src up one slot, walking down to the insert point
                mem_we  = 1'b1;
                wr_addr = src_reg + 1'b1;
                if (CNT_W'(src_reg) == idx_reg)
                begin
                    state_next = S_WRNEW;
                end
                else
                begin
                    rd_addr  = src_reg - 1'b1;
                    src_next = src_reg - 1'b1;
                end
            end

            S_WRNEW:
            begin
                mem_we          = 1'b1;
                wr_addr         = idx_reg[IDX_W-1:0];
                wr_data.key     = item_reg.key;
                wr_data.frames  = item_reg.use_all_in ? '0 : item_reg.value;
                wr_data.use_all = item_reg.use_all_in;
                count_next      = count_reg + 1'b1;
                state_next      = S_RESP;
            end

            S_SHDN:
            begin
                // move entry src down one slot, walking up to the last entry
                mem_we  = 1'b1;
                wr_addr = src_reg - 1'b1;
                if ((CNT_W'(src_reg) + 1'b1) == count_reg)
                begin
                    count_next = count_m1;
                    state_next = S_RESP;
                end
                else
                begin
                    rd_addr  = src_reg + 1'b1;
                    src_next = src_reg + 1'b1;
                end
            end

            S_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_next       = res_reg;
        rsp_next.count = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && !rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        src_reg  <= src_next;
        prev_reg <= prev_next;
        res_reg  <= res_next;
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `STT_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1,
        count_reg <= CNT_W'(DEPTH), "entry count exceeds table depth")
    `STT_ASSERT_IMPL(a_write_state, clk, rst_n, mem_we,
        (state_reg == S_SHUP) || (state_reg == S_SHDN) || (state_reg == S_WRNEW),
        "table write outside shift or insert")
    `STT_ASSERT_IMPL(a_scan_index, clk, rst_n, state_reg == S_SCAN,
        idx_reg <= count_reg, "scan index ran past entry count")
    `STT_ASSERT_NEXT(a_insert_count, clk, rst_n, state_reg == S_WRNEW,
        count_reg == ($past(count_reg) + 1'b1), "insert did not bump entry count")
    `STT_ASSERT_NEXT(a_accept_start, clk, rst_n, req_valid && !req_stall,
        state_reg == S_START, "accepted transaction did not start")

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted threshold table unit testbench
// Walks a short table of directed transactions, then phases of random
// add, remove, lookup, by-level, exists and unused-op traffic, keys mostly
// from a small pool, so the table fills, rejects duplicates and drains. Each
// response is checked against a fixed answer or a behavioral bench table.
// ----------------------------------------------------------------------------
module tb;
    import stt_pkg::*;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
    localparam int         POOL_SIZE       = 32;
    localparam int         PHASES          = 12;
    localparam int         PHASE_ITEMS     = 100;
    localparam int         LONG_HOLD       = 300;
    localparam int         DRAIN_CYCLES    = 64;
    localparam int         MAX_REPORTS     = 10;

    typedef struct {
        req_t  r;
        bit    typed;
        rsp_t  want;
    } plan_row_t;

    logic  clk;
    logic  rst_n;
    logic  req_valid;
    logic  req_stall;
    req_t  req;
    logic  rsp_valid;
    logic  rsp_stall;
    rsp_t  rsp;

    // Bench copy of the table
    logic [15:0] tab_key   [DEPTH];
    logic [15:0] tab_frames[DEPTH];
    logic        tab_all   [DEPTH];
    int          tab_cnt;

    rsp_t        pending_rsp[$];
    plan_row_t   plan[$];
    logic [15:0] key_pool[POOL_SIZE];
    int          mismatches;
    bit          snd_burst;
    bit          rcv_burst;
    int          long_hold;

    sorted_threshold_table_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Applies one transaction to the bench table and returns the response.
    function automatic rsp_t table_predict(req_t r);
        rsp_t o;
        int   pos;
        int   n;
        int   idx;
        int   i;
        bit   hit;
        o = '0;
        pos = 0;
        while (pos < tab_cnt && tab_key[pos] < r.key)
            pos++;
        hit = (pos < tab_cnt) && (tab_key[pos] == r.key);
        case (r.op)
            OP_ADD:
            begin
                if (hit)
                    o.status = ST_DUP;
                else if (tab_cnt >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    for (i = tab_cnt; i > pos; i--)
                    begin
                        tab_key[i]    = tab_key[i - 1];
                        tab_frames[i] = tab_frames[i - 1];
                        tab_all[i]    = tab_all[i - 1];
                    end
                    tab_key[pos]    = r.key;
                    tab_frames[pos] = r.use_all_in ? 16'd0 : r.value;
                    tab_all[pos]    = r.use_all_in;
                    tab_cnt++;
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    for (i = pos; i + 1 < tab_cnt; i++)
                    begin
                        tab_key[i]    = tab_key[i + 1];
                        tab_frames[i] = tab_frames[i + 1];
                        tab_all[i]    = tab_all[i + 1];
                    end
                    tab_cnt--;
                end
            end
            OP_LOOKUP:
            begin
                n = 0;
                while (n < tab_cnt && tab_key[n] <= r.key)
                    n++;
                o.level_out = n[4:0];
                if (n == 0)
                    o.use_all = 1'b1;
                else
                begin
                    o.use_all = tab_all[n - 1];
                    o.frames  = tab_all[n - 1] ? 16'd0 : tab_frames[n - 1];
                end
            end
            OP_LEVEL:
            begin
                if (tab_cnt == 0 || r.level == 0)
                    o.use_all = 1'b1;
                else
                begin
                    idx = (r.level > tab_cnt) ? tab_cnt - 1 : r.level - 1;
                    o.entry_key = tab_key[idx];
                    o.use_all   = tab_all[idx];
                    o.frames    = tab_all[idx] ? 16'd0 : tab_frames[idx];
                end
            end
            OP_EXISTS:
                o.found = hit;
            default:
                ;
        endcase
        o.count = tab_cnt[4:0];
        return o;
    endfunction

    function automatic req_t mk_req(logic [2:0] op, logic [15:0] key, logic [15:0] value,
                                    logic all, logic [4:0] lvl);
        req_t r;
        r.op         = op;
        r.key        = key;
        r.value      = value;
        r.use_all_in = all;
        r.level      = lvl;
        return r;
    endfunction

    // Only status, use_all, found and count are ever nonzero in typed rows.
    function automatic rsp_t mk_rsp(status_t st, logic all, logic hit, logic [4:0] cnt);
        rsp_t o;
        o         = '0;
        o.status  = st;
        o.use_all = all;
        o.found   = hit;
        o.count   = cnt;
        return o;
    endfunction

    task automatic add_row(req_t r, bit typed, rsp_t want);
        plan_row_t row;
        row.r     = r;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    function automatic logic [15:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55 || (roll < 80 && tab_cnt == 0))
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (roll < 80)
            return tab_key[$urandom_range(0, tab_cnt - 1)];
        else if (roll < 90)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)] + 16'($urandom_range(0, 2)) - 16'd1;
        return 16'($urandom());
    endfunction

    // mode 0 fills the table, 1 drains it, 2 is a mix leaning toward adds
    function automatic req_t random_req(int mode);
        req_t r;
        int   roll;
        int   add_lim;
        int   rem_lim;
        roll = $urandom_range(0, 99);
        add_lim = (mode == 0) ? 55 : (mode == 1) ? 15 : 30;
        rem_lim = (mode == 0) ? 65 : (mode == 1) ? 55 : 50;
        if (roll < add_lim)
            r.op = OP_ADD;
        else if (roll < rem_lim)
            r.op = OP_REMOVE;
        else if (roll < rem_lim + 18)
            r.op = OP_LOOKUP;
        else if (roll < rem_lim + 28)
            r.op = OP_LEVEL;
        else if (roll < 96)
            r.op = OP_EXISTS;
        else
            r.op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        r.key        = pick_key();
        r.value      = 16'($urandom());
        r.use_all_in = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) != 0)
            r.level = 5'($urandom_range(0, tab_cnt + 1));
        else
            r.level = 5'($urandom_range(0, 31));
        return r;
    endfunction

    task automatic send_request(req_t r, bit typed, rsp_t want);
        int   gap;
        rsp_t model_rsp;
        gap = snd_burst ? 0 : $urandom_range(0, 13);
        @(negedge clk);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        // the table must still be advanced on rows with a typed answer
        model_rsp = table_predict(r);
        pending_rsp.push_back(typed ? want : model_rsp);
    endtask

    task automatic report_mismatch(string what, rsp_t want, rsp_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s exp st=%0d fr=%h ua=%0d lv=%0d ek=%h fd=%0d ct=%0d",
                     $realtime, what, want.status, want.frames, want.use_all,
                     want.level_out, want.entry_key, want.found, want.count,
                     " got st=%0d fr=%h ua=%0d lv=%0d ek=%h fd=%0d ct=%0d",
                     got.status, got.frames, got.use_all, got.level_out,
                     got.entry_key, got.found, got.count);
    endtask

    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected transaction", '0, rsp);
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status || rsp.frames !== want.frames ||
                    rsp.use_all !== want.use_all || rsp.level_out !== want.level_out ||
                    rsp.entry_key !== want.entry_key || rsp.found !== want.found ||
                    rsp.count !== want.count)
                    report_mismatch("response mismatch", want, rsp);
            end
        end
    end

    // Response side: per-transaction stall, plus the occasional long hold
    initial
    begin : rsp_side
        int n;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold != 0)
            begin
                n = long_hold;
                long_hold = 0;
            end
            else
                n = rcv_burst ? 0 : $urandom_range(0, 13);
            if (n != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
        end
    end

    initial
    begin : stimulus
        int i;
        int ph;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req        = '0;
        mismatches = 0;
        snd_burst  = 1'b0;
        rcv_burst  = 1'b0;
        long_hold  = 0;
        tab_cnt    = 0;
        key_pool[0] = 16'd0;
        key_pool[1] = 16'd1;
        key_pool[2] = 16'hFFFF;
        key_pool[3] = 16'hFFFE;
        key_pool[4] = 16'h8000;
        key_pool[5] = 16'h7FFF;
        for (i = 6; i < POOL_SIZE; i++)
            key_pool[i] = 16'($urandom());

        add_row(mk_req(OP_LOOKUP, 16'd0, 16'd0, 1'b0, 5'd0), 1'b1, mk_rsp(ST_OK, 1'b1, 1'b0, 5'd0));
        add_row(mk_req(OP_LEVEL, 16'd0, 16'd0, 1'b0, 5'd5), 1'b1, mk_rsp(ST_OK, 1'b1, 1'b0, 5'd0));
        add_row(mk_req(OP_EXISTS, 16'd0, 16'd0, 1'b0, 5'd0), 1'b1, mk_rsp(ST_OK, 1'b0, 1'b0, 5'd0));
        add_row(mk_req(OP_REMOVE, 16'd7, 16'd0, 1'b0, 5'd0), 1'b1, mk_rsp(ST_OK, 1'b0, 1'b0, 5'd0));
        add_row(mk_req(OP_ADD, 16'd100, 16'd0, 1'b0, 5'd0), 1'b1, mk_rsp(ST_OK, 1'b0, 1'b0, 5'd1));
        add_row(mk_req(OP_ADD, 16'hFFFF, 16'hFFFF, 1'b1, 5'd31), 1'b1,
                mk_rsp(ST_OK, 1'b0, 1'b0, 5'd2));
        add_row(mk_req(OP_ADD, 16'd0, 16'hFFFF, 1'b0, 5'd0), 1'b1, mk_rsp(ST_OK, 1'b0, 1'b0, 5'd3));
        add_row(mk_req(OP_ADD, 16'd100, 16'd9, 1'b0, 5'd0), 1'b1, mk_rsp(ST_DUP, 1'b0, 1'b0, 5'd3));
        add_row(mk_req(OP_LOOKUP, 16'd99, 16'd0, 1'b0, 5'd0), 1'b0, '0);
        add_row(mk_req(OP_LOOKUP, 16'd0, 16'd0, 1'b0, 5'd0), 1'b0, '0);
        add_row(mk_req(OP_LOOKUP, 16'hFFFF, 16'd0, 1'b0, 5'd0), 1'b0, '0);
        add_row(mk_req(OP_LOOKUP, 16'd100, 16'd0, 1'b0, 5'd0), 1'b0, '0);
        add_row(mk_req(OP_LEVEL, 16'd0, 16'd0, 1'b0, 5'd0), 1'b1, mk_rsp(ST_OK, 1'b1, 1'b0, 5'd3));
        add_row(mk_req(OP_LEVEL, 16'd0, 16'd0, 1'b0, 5'd1), 1'b0, '0);
        add_row(mk_req(OP_LEVEL, 16'd0, 16'd0, 1'b0, 5'd3), 1'b0, '0);
        add_row(mk_req(OP_LEVEL, 16'd0, 16'd0, 1'b0, 5'd16), 1'b0, '0);
        add_row(mk_req(OP_LEVEL, 16'd0, 16'd0, 1'b0, 5'd31), 1'b0, '0);
        add_row(mk_req(OP_EXISTS, 16'hFFFF, 16'd0, 1'b0, 5'd0), 1'b1,
                mk_rsp(ST_OK, 1'b0, 1'b1, 5'd3));
        add_row(mk_req(OP_EXISTS, 16'd50, 16'd0, 1'b0, 5'd0), 1'b1, mk_rsp(ST_OK, 1'b0, 1'b0, 5'd3));
        add_row(mk_req(OP_REMOVE, 16'd0, 16'd0, 1'b0, 5'd0), 1'b1, mk_rsp(ST_OK, 1'b0, 1'b0, 5'd2));
        add_row(mk_req(OP_REMOVE, 16'd0, 16'd0, 1'b0, 5'd0), 1'b1, mk_rsp(ST_OK, 1'b0, 1'b0, 5'd2));
        add_row(mk_req(OP_UNUSED_FIRST, 16'hFFFF, 16'hFFFF, 1'b1, 5'd31), 1'b1,
                mk_rsp(ST_OK, 1'b0, 1'b0, 5'd2));
        add_row(mk_req(OP_UNUSED_LAST, 16'd100, 16'd0, 1'b0, 5'd1), 1'b1,
                mk_rsp(ST_OK, 1'b0, 1'b0, 5'd2));
        add_row(mk_req(OP_ADD, 16'h8000, 16'h5555, 1'b0, 5'd0), 1'b0, '0);
        add_row(mk_req(OP_LOOKUP, 16'd40000, 16'd0, 1'b0, 5'd0), 1'b0, '0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
            send_request(plan[i].r, plan[i].typed, plan[i].want);

        for (ph = 0; ph < PHASES; ph++)
        begin
            snd_burst = (ph % 4 == 1);
            rcv_burst = (ph % 4 == 2);
            // long receiver hold while requests keep coming back to back
            if (ph == 4 || ph == 9)
            begin
                snd_burst = 1'b1;
                long_hold = LONG_HOLD;
            end
            for (i = 0; i < PHASE_ITEMS; i++)
                send_request(random_req(ph % 3), 1'b0, '0);
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
